>>> sv/itrd_pkg.sv
package itrd_pkg;

    // Width of the integer that is converted.
    localparam int VALUE_BITS = 31;

    // Radix register and its legal range.
    localparam int RADIX_W = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // Character and digit encoding.
    localparam int CHAR_W = 7;
    localparam int DIGIT_W = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(65);
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);

    // Digit counter and digit store index widths.
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    // Job queue between the front and back parts.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One conversion job: the value, its radix and the radix reciprocal.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        logic [VALUE_BITS-1:0] recip;
    } job_t;

    // A job together with its valid flag, as passed between the parts.
    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

    // Map a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_DIGITS)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_ALPHA + CHAR_W'(d - DECIMAL_DIGITS);
        end
        return c;
    endfunction

endpackage

>>> sv/integer_to_radix_digits.sv
// Integer to radix digits converter.
// Input channel: in_valid / in_stall with value; a transfer happens when
// in_valid is high and in_stall is low. Each value produces a run of ASCII
// digit characters on the output channel (out_valid / out_stall with
// digit_char and last), most significant digit first, last set on the final
// character. Zero produces the single character '0'.
// The radix is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Values below 2 act as 2 and above 36 act as 36. Reset sets it to 10.
// A two-entry job queue lets the input side accept items while a conversion
// runs. Each digit is found by a reciprocal multiply, then a correction;
// all digits of an item are computed before its first character is emitted,
// at most 31 digits in binary. The converter works on one item at a time and
// takes a new item from the queue only after the last character of the
// previous one has been emitted.
// When the receiver stalls, the output register holds its character and the
// converter waits; further inputs collect in the queue until it fills.
// Reset clears the queue, the sequencer and the output valid; no clearing
// pass is needed.
module integer_to_radix_digits (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [itrd_pkg::RADIX_W-1:0]     cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [itrd_pkg::VALUE_BITS-1:0]  value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]      digit_char,
    output logic                             last
);
    import itrd_pkg::*;

    job_req_t push;
    job_req_t head;
    logic     fifo_full;
    logic     pop;

    // Front part: radix register, clamping and reciprocal lookup.
    itrd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .fifo_full   (fifo_full),
        .push        (push)
    );

    // Job queue between the two parts.
    itrd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (fifo_full),
        .head  (head),
        .pop   (pop)
    );

    // Back part: repeated division and reversed emission.
    itrd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

>>> sv/itrd_front.sv
module itrd_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [itrd_pkg::RADIX_W-1:0]     cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [itrd_pkg::VALUE_BITS-1:0]  value,
    input  logic                             fifo_full,
    output itrd_pkg::job_req_t               push
);
    import itrd_pkg::*;

    localparam logic [VALUE_BITS:0] POW = {1'b1, {VALUE_BITS{1'b0}}};

    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    radix_next;
    logic [RADIX_W-1:0]    eff_radix;
    logic [VALUE_BITS-1:0] recip_tab [RADIX_MIN:RADIX_MAX];

    // Reciprocal table: floor(2^VALUE_BITS / r) for every legal radix.
    for (genvar g = RADIX_MIN; g <= RADIX_MAX; g++)
    begin : g_recip
        localparam logic [VALUE_BITS:0] RECIP = POW / (VALUE_BITS + 1)'(g);
        assign recip_tab[g] = RECIP[VALUE_BITS-1:0];
    end

    // Radix register, written from the configuration port.
    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr_en)
        begin
            radix_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // Clamp the radix into its legal range.
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            eff_radix = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix = RADIX_MAX;
        end
        else
        begin
            eff_radix = radix_reg;
        end
    end

    // Build the job and push it whenever the queue has room.
    assign in_stall        = fifo_full;
    assign push.valid      = in_valid && !fifo_full;
    assign push.job.value  = value;
    assign push.job.radix  = eff_radix;
    assign push.job.recip  = recip_tab[eff_radix];

endmodule

>>> sv/itrd_fifo.sv
module itrd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  itrd_pkg::job_req_t  push,
    output logic                full,
    output itrd_pkg::job_req_t  head,
    input  logic                pop
);
    import itrd_pkg::*;

    job_t                  ent_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  do_pop;

    assign full       = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.job   = ent_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid)
        begin
            wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push.valid && !do_pop)
        begin
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        end
        else if (do_pop && !push.valid)
        begin
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            ent_reg[wr_ptr_reg] <= push.job;
        end
    end

    // A push never lands on a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("job queue overflow");

    // Occupancy never exceeds the depth.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("job queue count out of range");

endmodule

>>> sv/itrd_back.sv
module itrd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  itrd_pkg::job_req_t              head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]     digit_char,
    output logic                            last
);
    import itrd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [CHAR_W-1:0]       char_reg;
    logic [CHAR_W-1:0]       char_next;
    logic                    last_reg;
    logic                    last_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        idx_next;
    logic [VALUE_BITS-1:0]   rem_reg;
    logic [VALUE_BITS-1:0]   rem_next;
    logic [RADIX_W-1:0]      radix_reg;
    logic [RADIX_W-1:0]      radix_next;
    logic [VALUE_BITS-1:0]   recip_reg;
    logic [VALUE_BITS-1:0]   recip_next;
    logic [2*VALUE_BITS-1:0] prod_reg;
    logic [2*VALUE_BITS-1:0] prod_next;
    logic [DIGIT_W-1:0]      store_reg [VALUE_BITS];

    logic                    store_we;
    logic [IDX_W-1:0]        store_addr;
    logic [DIGIT_W-1:0]      store_din;
    logic                    out_free;

    logic [VALUE_BITS-1:0]   fix_qest;
    logic [6:0]              fix_prod7;
    logic [6:0]              fix_low;
    logic                    fix_over;
    logic [DIGIT_W-1:0]      fix_digit;
    logic [VALUE_BITS-1:0]   fix_quot;

    // Quotient estimate from the reciprocal product, then one correction step.
    // The estimate is low by at most one, so the remainder stays below twice
    // the radix and only its low seven bits matter.
    assign fix_qest  = prod_reg[2*VALUE_BITS-1:VALUE_BITS];
    assign fix_prod7 = 7'(fix_qest[6:0] * 7'(radix_reg));
    assign fix_low   = rem_reg[6:0] - fix_prod7;
    assign fix_over  = (fix_low >= 7'(radix_reg));
    assign fix_digit = fix_over ? DIGIT_W'(fix_low - 7'(radix_reg)) : fix_low[DIGIT_W-1:0];
    assign fix_quot  = fix_over ? fix_qest + VALUE_BITS'(1) : fix_qest;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: take a job, divide digit by digit, then emit in reverse.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        recip_next     = recip_reg;
        prod_next      = prod_reg;
        store_we       = 1'b0;
        store_addr     = cnt_reg[IDX_W-1:0];
        store_din      = fix_digit;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    rem_next   = head.job.value;
                    radix_next = head.job.radix;
                    recip_next = head.job.recip;
                    cnt_next   = '0;
                    if (head.job.value == '0)
                    begin
                        // Zero gives the single digit zero.
                        store_we   = 1'b1;
                        store_addr = '0;
                        store_din  = '0;
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = (2*VALUE_BITS)'(rem_reg) * (2*VALUE_BITS)'(recip_reg);
                state_next = S_FIX;
            end
            S_FIX:
            begin
                store_we = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                rem_next = fix_quot;
                if (fix_quot == '0 || cnt_next == CNT_W'(VALUE_BITS))
                begin
                    idx_next   = cnt_reg[IDX_W-1:0];
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = to_ascii(store_reg[idx_reg]);
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath registers and the digit store.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        recip_reg <= recip_next;
        prod_reg  <= prod_next;
        if (store_we)
        begin
            store_reg[store_addr] <= store_din;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    // One correction step is always enough.
    a_fix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIX |-> fix_low < {radix_reg, 1'b0})
        else $error("remainder needs more than one correction");

    // A taken job carries a radix in the legal range.
    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head.job.radix >= RADIX_MIN) && (head.job.radix <= RADIX_MAX))
        else $error("job radix out of range");

    // The digit count never exceeds the store depth.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count out of range");

endmodule
